// ===== rtl/core/idnl_pkg.sv =====
`default_nettype none

package idnl_pkg;

	// special characters of the database text
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_NL   = 8'h0A;

	// configuration register indexes
	localparam logic CFG_WANTED_VENDOR = 1'b0;
	localparam logic CFG_WANTED_DEVICE = 1'b1;

	// result queue depth and pointer width
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		KIND_VENDOR_CHAR = 2'd0,
		KIND_DEVICE_CHAR = 2'd1,
		KIND_VENDOR_END  = 2'd2,
		KIND_FINISHED    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  name_char;
		logic        vendor_found;
		logic        device_found;
		logic        last;
	} result_t;

	// zero, one or two results produced by one byte
	typedef struct packed {
		logic [1:0]  count;
		result_t     r0;
		result_t     r1;
	} push_t;

	// hex digit value, non-hex characters count as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = c - 8'h57;
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = c - 8'h37;
			end
			hex_value = d[3:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/idnl_parse.sv =====
`default_nettype none

module idnl_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [7:0]        text_byte,
	input  wire logic              first_byte,
	input  wire logic              final_byte,
	input  wire logic [15:0]       wanted_vendor,
	input  wire logic [15:0]       wanted_device,
	output idnl_pkg::push_t        push
);
	import idnl_pkg::*;

	typedef struct packed {
		logic [2:0]  column;
		logic [15:0] line_vendor;
		logic [15:0] line_device;
		logic [15:0] section_vendor;
		logic        is_vendor_line;
		logic        is_device_line;
		logic        skip_rest;
		logic        line_starts_tab;
		logic        fnd_vendor;
		logic        fnd_device;
		logic        vend_sent;
		logic        finished;
	} parse_state_t;

	localparam parse_state_t CLEAR_STATE = '{
		column:          3'd0,
		line_vendor:     16'd0,
		line_device:     16'd0,
		section_vendor:  16'd0,
		is_vendor_line:  1'b1,
		is_device_line:  1'b1,
		skip_rest:       1'b0,
		line_starts_tab: 1'b0,
		fnd_vendor:      1'b0,
		fnd_device:      1'b0,
		vend_sent:       1'b0,
		finished:        1'b0
	};

	parse_state_t state_q;
	parse_state_t nxt;

	// one byte of parsing: state update and up to two results
	always_comb begin
		parse_state_t st;
		logic [2:0]   col;
		logic         act;
		logic         vc;
		logic         dc;
		logic [1:0]   cd;
		logic [1:0]   n;
		kind_t        k0;
		kind_t        k1;
		logic [7:0]   c0;
		logic [7:0]   c1;

		st  = first_byte ? CLEAR_STATE : state_q;
		nxt = st;
		col = st.column;
		act = 1'b1;
		vc  = 1'b0;
		dc  = 1'b0;
		cd  = 2'(col - 3'd1);
		n   = 2'd0;
		k0  = KIND_FINISHED;
		k1  = KIND_FINISHED;
		c0  = 8'd0;
		c1  = 8'd0;

		if (!st.finished) begin
			if (text_byte == CH_NL) begin
				// end of line clears the line state
				nxt.column          = 3'd0;
				nxt.line_vendor     = 16'd0;
				nxt.line_device     = 16'd0;
				nxt.skip_rest       = 1'b0;
				nxt.is_vendor_line  = 1'b1;
				nxt.is_device_line  = 1'b1;
				nxt.line_starts_tab = 1'b0;
				if (st.fnd_vendor && !st.vend_sent) begin
					nxt.vend_sent = 1'b1;
					k0 = KIND_VENDOR_END;
					n  = 2'd1;
				end
				if (st.fnd_device) begin
					nxt.finished = 1'b1;
					if (n == 2'd0) begin
						k0 = KIND_FINISHED;
					end else begin
						k1 = KIND_FINISHED;
					end
					n = n + 2'd1;
				end
			end else begin
				if (col != 3'd7) begin
					nxt.column = col + 3'd1;
				end
				if (col == 3'd0) begin
					nxt.line_starts_tab = (text_byte == CH_TAB);
				end
				// early exits of the character parser
				if (!st.fnd_vendor && nxt.line_starts_tab) begin
					act = 1'b0;
				end
				if (act && st.skip_rest) begin
					act = 1'b0;
				end
				if (act && text_byte == CH_HASH) begin
					nxt.skip_rest = 1'b1;
					act = 1'b0;
				end
				if (act && !st.is_vendor_line && col < 3'd1) begin
					act = 1'b0;
				end
				if (act && !st.is_device_line && col < 3'd2) begin
					act = 1'b0;
				end
				// vendor id digits in columns 0..3
				if (act && col < 3'd4 && st.is_vendor_line) begin
					if (text_byte == CH_TAB) begin
						nxt.is_vendor_line = 1'b0;
						act = 1'b0;
					end else begin
						nxt.line_vendor = st.line_vendor |
							(16'(hex_value(text_byte)) << {~col[1:0], 2'b00});
					end
				end
				// device id digits in columns 1..4
				if (act && col >= 3'd1 && col < 3'd5 && !nxt.is_vendor_line) begin
					if (text_byte == CH_TAB) begin
						nxt.is_device_line = 1'b0;
						act = 1'b0;
					end else begin
						nxt.line_device = st.line_device |
							(16'(hex_value(text_byte)) << {~cd, 2'b00});
					end
				end
				if (act && col == 3'd4 && nxt.is_vendor_line) begin
					nxt.section_vendor = nxt.line_vendor;
				end
				// name characters
				if (act && nxt.is_vendor_line && nxt.section_vendor == wanted_vendor &&
					col >= 3'd6) begin
					vc = 1'b1;
					nxt.fnd_vendor = 1'b1;
				end
				if (act && nxt.is_device_line && nxt.line_device == wanted_device &&
					nxt.section_vendor == wanted_vendor && col == 3'd7) begin
					dc = 1'b1;
					nxt.fnd_device = 1'b1;
				end
				if (vc) begin
					k0 = KIND_VENDOR_CHAR;
					c0 = text_byte;
					n  = 2'd1;
				end
				if (dc && !(final_byte && vc)) begin
					if (n == 2'd0) begin
						k0 = KIND_DEVICE_CHAR;
						c0 = text_byte;
					end else begin
						k1 = KIND_DEVICE_CHAR;
						c1 = text_byte;
					end
					n = n + 2'd1;
				end
			end
			// final byte closes the lookup
			if (final_byte && !nxt.finished) begin
				nxt.finished = 1'b1;
				if (n == 2'd0) begin
					k0 = KIND_FINISHED;
					c0 = 8'd0;
				end else begin
					k1 = KIND_FINISHED;
					c1 = 8'd0;
				end
				n = n + 2'd1;
			end
		end

		push.count           = n;
		push.r0.kind         = k0;
		push.r0.name_char    = c0;
		push.r0.vendor_found = nxt.fnd_vendor;
		push.r0.device_found = nxt.fnd_device;
		push.r0.last         = (n == 2'd1);
		push.r1.kind         = k1;
		push.r1.name_char    = c1;
		push.r1.vendor_found = nxt.fnd_vendor;
		push.r1.device_found = nxt.fnd_device;
		push.r1.last         = 1'b1;
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR_STATE;
		end else if (take) begin
			state_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/idnl_queue.sv =====
`default_nettype none

module idnl_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_en,
	input  wire idnl_pkg::push_t   push,
	output logic                   room,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output idnl_pkg::result_t      res
);
	import idnl_pkg::*;

	result_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]    wptr_q;
	logic [QUEUE_AW-1:0]    rptr_q;
	logic [QUEUE_AW:0]      count_q;
	logic [1:0]             n_push;
	logic                   pop;

	// room for two more results
	assign room      = (count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
	assign res_valid = (count_q != '0);
	assign res       = mem_q[rptr_q];
	assign pop       = res_valid && res_ready;
	assign n_push    = push_en ? push.count : 2'd0;

	// result storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (n_push == 2'd2) begin
			mem_q[wptr_q + QUEUE_AW'(1)] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + QUEUE_AW'(n_push);
			rptr_q  <= rptr_q + QUEUE_AW'(pop);
			count_q <= count_q + (QUEUE_AW+1)'(n_push) - (QUEUE_AW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/id_database_name_lookup.sv =====
// ID database name lookup
//
// Bytes of a text ID database come in on the text request channel
// (text_valid/text_ready) with first_byte marking the start of a lookup and
// final_byte the last byte. Results leave on the res channel
// (res_valid/res_ready): vendor and device name characters, a vendor-end mark
// and one finish result carrying both found flags; last marks the final
// result of a byte. wanted_vendor and wanted_device are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the block is
// idle; the block itself does not enforce this.
//
// A byte is taken into an input register, parsed from there once the queue
// has room, and its results are written into a four-entry result queue. One
// byte is accepted per cycle as long as the queue has room for two results;
// a byte that yields two results fills two queue entries, so the sustained
// rate follows the drain rate of the res channel. When the receiver stalls,
// the queue fills and text_ready drops; nothing is lost. Reset clears the
// parse state, the queue and both configuration registers.

`default_nettype none

module id_database_name_lookup (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        first_byte,
	input  wire logic        final_byte,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [1:0]       kind,
	output logic [7:0]       name_char,
	output logic             vendor_found,
	output logic             device_found,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	import idnl_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        final_s1;
	logic [15:0] wanted_vendor_q;
	logic [15:0] wanted_device_q;
	logic        room;
	logic        take;
	push_t       push;
	result_t     res;

	assign take       = valid_s1 && room;
	assign text_ready = !valid_s1 || room;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_vendor_q <= 16'd0;
			wanted_device_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WANTED_VENDOR: wanted_vendor_q <= cfg_data;
				CFG_WANTED_DEVICE: wanted_device_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			byte_s1  <= text_byte;
			first_s1 <= first_byte;
			final_s1 <= final_byte;
		end
	end

	idnl_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.text_byte     (byte_s1),
		.first_byte    (first_s1),
		.final_byte    (final_s1),
		.wanted_vendor (wanted_vendor_q),
		.wanted_device (wanted_device_q),
		.push          (push)
	);

	idnl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (take),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// result fields
	assign kind         = res.kind;
	assign name_char    = res.name_char;
	assign vendor_found = res.vendor_found;
	assign device_found = res.device_found;
	assign last         = res.last;

endmodule

`default_nettype wire
